[rtl/online_logistic_regression_unit_core_defines.svh]
// Assertion macros for the online logistic regression unit core.
// The macros expect signals named clk and rst in the including module.
`ifndef ONLINE_LOGISTIC_REGRESSION_UNIT_CORE_DEFINES_SVH
`define ONLINE_LOGISTIC_REGRESSION_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OLRU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olru assertion failed");

// Next-cycle implication, disabled during reset.
`define OLRU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olru assertion failed");

`endif

[rtl/olru_pkg.sv]
// Shared types, constants and the sigmoid table of the logistic regression unit.
// Depends on nothing; used by online_logistic_regression_unit_core, olru_monitor and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package olru_pkg;

  localparam int DEFAULT_MAX_FEATURES = 64;
  localparam int SIG_DEPTH = 256;
  localparam int SIG_HALF = SIG_DEPTH / 2;
  localparam int SIG_SHIFT = 28 - $clog2(SIG_DEPTH);
  localparam logic [15:0] LR_RESET = 16'd6554;
  localparam logic [6:0] NF_RESET = 7'd64;
  localparam logic signed [31:0] WEIGHT_RESET = 32'sd6554;

  typedef enum logic [0:0] {
    REG_LEARNING_RATE = 1'b0,
    REG_NUM_FEATURES  = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_ACC,
    S_NET,
    S_SIG,
    S_TA,
    S_TB,
    S_TC,
    S_TD,
    S_TW1,
    S_TW2
  } state_t;

  typedef logic [15:0] sig_tab_t [SIG_DEPTH];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig();
    sig_tab_t tab;
    logic [63:0] pw [SIG_DEPTH + 2];
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e30;
    logic [63:0] den;
    logic [63:0] p;
    int mag;
    term = 64'd1 << 56;
    pos = term;
    neg = '0;
    for (int n = 1; n <= 30; n++) begin
      term = udiv64(term * 64'd16, 64'(SIG_DEPTH) * 64'(n));
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    e30 = (pos - neg + (64'd1 << 25)) >> 26;
    pw[0] = 64'd1 << 30;
    for (int k = 1; k < SIG_DEPTH + 2; k++) begin
      pw[k] = (pw[k - 1] * e30 + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < SIG_DEPTH; k++) begin
      mag = (k >= SIG_HALF) ? (k - SIG_HALF) : (SIG_HALF - k);
      den = (64'd1 << 30) + pw[mag];
      p = udiv64((64'd1 << 46) + (den >> 1), den);
      if (k < SIG_HALF) p = 64'd65536 - p;
      if (p > 64'd65535) p = 64'd65535;
      tab[k] = p[15:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig();

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/online_logistic_regression_unit_core.sv]
// Top level of the online logistic regression unit: sequencer, memories and
// one shared multiplier. Depends on olru_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "online_logistic_regression_unit_core_defines.svh"

// Usage:
// Each input request carries one feature of an instance in index order, with op
// and label. A request is taken when in_valid is high and in_stall is low.
// A feature passes three steps (weight read, multiply, accumulate) through the
// single shared multiplier; a new feature is taken once the one before is done.
// For the last feature of an instance the net sum, bias included, is registered
// in the accumulate step; the NET and SIG states follow, and in SIG the sigmoid
// table lookup is loaded into the output register once that register is free.
// With op set, training follows: the error term and bias in states S_TA to S_TD,
// then S_TW1 and S_TW2 per weight, all on one multiplier; in_stall stays high.
// The output register holds a result until out_stall is low. When a new result
// is ready while the old one is still stalled, the sequencer waits.
// After reset the weight memory is cleared to its reset value, one entry a
// cycle, over all MAX_FEATURES entries; in_stall is high during that pass.
// Configuration writes are taken at any time through cfg_we.
module online_logistic_regression_unit_core #(
  parameter int MAX_FEATURES = olru_pkg::DEFAULT_MAX_FEATURES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic signed [15:0] feature_value,
  input  wire logic        label,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      probability,
  output logic             predicted_class
);
  import olru_pkg::*;

  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W + 1 : 8;

  state_t state, state_next;

  logic [15:0] lr;
  logic [6:0] nf;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] rd_addr;
  logic signed [55:0] acc;
  logic signed [55:0] net;
  logic signed [31:0] bias;
  logic signed [51:0] prod;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic [15:0] p_reg;
  logic [32:0] c_reg;
  logic signed [15:0] x_reg;
  logic op_reg;
  logic label_reg;

  logic signed [31:0] wmem [MAX_FEATURES];
  logic signed [15:0] fmem [MAX_FEATURES];
  logic signed [31:0] w_q;
  logic signed [15:0] f_q;

  logic [CMP_W-1:0] nf_eff;
  logic last_hit;
  logic out_free;
  logic [50:0] prod_u;
  logic [32:0] r16;
  logic [16:0] bstep;
  logic [23:0] ws;
  logic [16:0] emag;
  logic [16:0] fmag;
  logic fneg;
  logic signed [31:0] w_new;
  logic signed [31:0] bias_new;
  logic signed [55:0] net_c;
  logic signed [55:0] net_r;
  logic [9:0] tidx;
  logic [7:0] sidx;

  logic accept;
  logic w_we;
  logic signed [31:0] w_wdata;

  // Arithmetic helpers.
  always_comb begin
    if (nf == 7'd0) begin
      nf_eff = CMP_W'(1);
    end else if (CMP_W'(nf) > CMP_W'(MAX_FEATURES)) begin
      nf_eff = CMP_W'(MAX_FEATURES);
    end else begin
      nf_eff = CMP_W'(nf);
    end
    last_hit = (CMP_W'(count) + CMP_W'(1)) >= nf_eff;
    out_free = !(out_valid && out_stall);
    prod_u = prod[50:0];
    r16 = 33'((prod_u + 51'd32768) >> 16);
    bstep = 17'(({1'b0, r16} + 34'd32768) >> 16);
    ws = 24'((prod_u + 51'd8388608) >> 24);
    emag = label_reg ? (17'd65536 - {1'b0, p_reg}) : {1'b0, p_reg};
    fneg = f_q[15];
    fmag = fneg ? (17'd0 - {{1{f_q[15]}}, f_q}) : {1'b0, f_q};
    if (label_reg) begin
      bias_new = sat32(34'(bias) + 34'(bstep));
    end else begin
      bias_new = sat32(34'(bias) - 34'(bstep));
    end
    if (label_reg == fneg) begin
      w_new = sat32(34'(w_q) - 34'(ws));
    end else begin
      w_new = sat32(34'(w_q) + 34'(ws));
    end
    if (net > 56'sd134217728) begin
      net_c = 56'sd134217728;
    end else if (net < -56'sd134217728) begin
      net_c = -56'sd134217728;
    end else begin
      net_c = net;
    end
    net_r = (net_c + (56'sd1 <<< (SIG_SHIFT - 1))) >>> SIG_SHIFT;
    tidx = net_r[9:0] + 10'(SIG_HALF);
    sidx = (tidx >= 10'(SIG_DEPTH)) ? 8'(SIG_DEPTH - 1) : tidx[7:0];
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL: begin
        mul_a = 34'(w_q);
        mul_b = 18'(x_reg);
      end
      S_TA: begin
        mul_a = {18'd0, p_reg};
        mul_b = {1'b0, 17'd65536 - {1'b0, p_reg}};
      end
      S_TB: begin
        mul_a = {1'b0, prod_u[32:0]};
        mul_b = {1'b0, emag};
      end
      S_TC: begin
        mul_a = {1'b0, r16};
        mul_b = {2'd0, lr};
      end
      S_TW1: begin
        mul_a = {1'b0, c_reg};
        mul_b = {1'b0, fmag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (idx == IDX_W'(MAX_FEATURES - 1)) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = last_hit ? S_NET : S_IDLE;
      S_NET:  state_next = S_SIG;
      S_SIG: begin
        if (out_free) state_next = op_reg ? S_TA : S_IDLE;
      end
      S_TA:   state_next = S_TB;
      S_TB:   state_next = S_TC;
      S_TC:   state_next = S_TD;
      S_TD:   state_next = S_TW1;
      S_TW1:  state_next = S_TW2;
      S_TW2:  state_next = (idx == last) ? S_IDLE : S_TW1;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = (state != S_IDLE);
    accept = in_valid && (state == S_IDLE);
    w_we = (state == S_CLR) || (state == S_TW2);
    w_wdata = (state == S_CLR) ? WEIGHT_RESET : w_new;
    unique case (state)
      S_IDLE:  rd_addr = count;
      S_TD:    rd_addr = '0;
      S_TW2:   rd_addr = idx + IDX_W'(1);
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[idx] <= w_wdata;
    if (accept) fmem[count] <= feature_value;
    w_q <= wmem[rd_addr];
    f_q <= fmem[rd_addr];
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= feature_value;
      op_reg <= op;
      label_reg <= label;
    end
    if (state == S_ACC) net <= acc + 56'(prod) + (56'(bias) <<< 8);
    if (state == S_SIG) p_reg <= SIG_TABLE[sidx];
    if (state == S_TD) c_reg <= r16;
    if (state == S_SIG && out_free) begin
      probability <= SIG_TABLE[sidx];
      predicted_class <= SIG_TABLE[sidx] > 16'd32768;
      last <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      lr <= LR_RESET;
      nf <= NF_RESET;
      count <= '0;
      idx <= '0;
      acc <= '0;
      bias <= WEIGHT_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_LEARNING_RATE) lr <= cfg_data;
      if (cfg_we && cfg_index == REG_NUM_FEATURES) nf <= cfg_data[6:0];
      if (state == S_ACC) begin
        if (last_hit) begin
          acc <= '0;
        end else begin
          acc <= acc + 56'(prod);
          count <= count + IDX_W'(1);
        end
      end
      if (state == S_SIG && out_free) count <= '0;
      if (state == S_CLR || state == S_TW2) idx <= idx + IDX_W'(1);
      if (state == S_TD) begin
        idx <= '0;
        bias <= bias_new;
      end
      if (state == S_SIG && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `OLRU_ASSERT_IMP(a_count_range, 1'b1, CMP_W'(count) < CMP_W'(MAX_FEATURES))
  `OLRU_ASSERT_IMP(a_train_index, state == S_TW1 || state == S_TW2, idx <= last)
  `OLRU_ASSERT_NXT(a_accept_mul, in_valid && !in_stall, state == S_MUL)

endmodule

`default_nettype wire

[dv/olru_monitor.sv]
// Watches the configuration, request and result channels of the logistic regression unit,
// predicts each result and compares it with what the unit delivers.
// Depends on olru_pkg for the register index codes and reset values.
`timescale 1ns / 1ps

module olru_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] feature_value,
  input  logic               label,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        probability,
  input  logic               predicted_class,
  output int                 fails,
  output int                 pending
);
  import olru_pkg::*;

  typedef struct packed {
    logic [15:0] prob;
    logic        cls;
  } verdict_t;

  verdict_t awaited[$];
  logic [15:0] sig_lut [256];
  logic [15:0] rate;
  logic [6:0] nf_reg;
  longint weights [64];
  longint feats [64];
  longint bias;
  longint dot_sum;
  int count;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic build_lut();
    longint unsigned term, pos, neg, e30, den, p;
    longint unsigned pw [258];
    int mag;
    term = 64'd1 << 56;
    pos = term;
    neg = 0;
    for (int n = 1; n <= 30; n++) begin
      term = (term * 64'd16) / (64'd256 * n);
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    e30 = (pos - neg + (64'd1 << 25)) >> 26;
    pw[0] = 64'd1 << 30;
    for (int k = 1; k < 258; k++) pw[k] = (pw[k - 1] * e30 + (64'd1 << 29)) >> 30;
    for (int k = 0; k < 256; k++) begin
      mag = (k >= 128) ? k - 128 : 128 - k;
      den = (64'd1 << 30) + pw[mag];
      p = ((64'd1 << 46) + den / 2) / den;
      if (k < 128) p = 65536 - p;
      if (p > 65535) p = 65535;
      sig_lut[k] = p[15:0];
    end
  endtask

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint squash(input longint net);
    longint lim, t, idx;
    lim = 64'sd8 <<< 24;
    if (net > lim) net = lim;
    if (net < -lim) net = -lim;
    t = net * 256 + (64'sd1 <<< 27) + 256 * (64'sd1 <<< 28);
    idx = (t >>> 28) - 256 + 128;
    if (idx < 0) idx = 0;
    if (idx > 255) idx = 255;
    return sig_lut[idx];
  endfunction

  task automatic take_feature(input logic o, input logic signed [15:0] x, input logic lab);
    int n;
    longint p, err, emag, a, b, c, bstep, fmag, ws;
    bit eneg, fneg;
    verdict_t v;
    n = (nf_reg == 0) ? 1 : (nf_reg > 64) ? 64 : nf_reg;
    if (count >= 64) count = 0;
    feats[count] = x;
    dot_sum += weights[count] * feats[count];
    if (count + 1 < n) begin
      count++;
      return;
    end
    p = squash(dot_sum + bias * 256);
    v.prob = p[15:0];
    v.cls = p > 32768;
    awaited.push_back(v);
    if (o) begin
      err = (lab ? 64'sd65536 : 64'sd0) - p;
      eneg = err < 0;
      emag = eneg ? -err : err;
      a = p * (65536 - p);
      b = (a * emag + 32768) >>> 16;
      c = (b * rate + 32768) >>> 16;
      bstep = (c + 32768) >>> 16;
      bias = sat(bias + (eneg ? -bstep : bstep));
      for (int i = 0; i <= count; i++) begin
        fneg = feats[i] < 0;
        fmag = fneg ? -feats[i] : feats[i];
        ws = (c * fmag + (64'sd1 <<< 23)) >>> 24;
        weights[i] = sat(weights[i] + ((eneg != fneg) ? -ws : ws));
      end
    end
    dot_sum = 0;
    count = 0;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    build_lut();
  end

  always @(posedge clk) begin
    verdict_t got;
    if (rst) begin
      awaited.delete();
      rate = LR_RESET;
      nf_reg = NF_RESET;
      for (int i = 0; i < 64; i++) weights[i] = 6554;
      bias = 6554;
      dot_sum = 0;
      count = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_LEARNING_RATE: rate = cfg_data;
          REG_NUM_FEATURES: nf_reg = cfg_data[6:0];
        endcase
      end
      if (in_valid && !in_stall) take_feature(op, feature_value, label);
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          got = awaited.pop_front();
          if (probability !== got.prob)
            report($sformatf("probability %0d, expected %0d", probability, got.prob));
          if (predicted_class !== got.cls)
            report($sformatf("class %0d, expected %0d", predicted_class, got.cls));
        end
      end
    end
    pending = awaited.size();
  end

endmodule

[dv/testbench.sv]
// Top of the logistic regression unit testbench: clock, reset, stimulus and verdict.
// Depends on olru_pkg, online_logistic_regression_unit_core and olru_monitor.
`timescale 1ns / 1ps

module testbench;
  import olru_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic signed [15:0] feature_value = '0;
  logic label = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] probability;
  logic predicted_class;
  int fails;
  int pending;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  online_logistic_regression_unit_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .feature_value(feature_value),
    .label(label), .out_valid(out_valid), .out_stall(out_stall),
    .probability(probability), .predicted_class(predicted_class)
  );

  olru_monitor monitor (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .feature_value(feature_value),
    .label(label), .out_valid(out_valid), .out_stall(out_stall),
    .probability(probability), .predicted_class(predicted_class),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic set_config(input logic [15:0] lr, input logic [6:0] nf);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEARNING_RATE;
    cfg_data <= lr;
    @(posedge clk);
    cfg_index <= REG_NUM_FEATURES;
    cfg_data <= {9'd0, nf};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input logic o, input logic signed [15:0] x, input logic lab);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    feature_value <= x;
    label <= lab;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] lr, input logic [6:0] nf, input int items);
    int n, sent, mode;
    logic o, lab;
    logic signed [15:0] x;
    n = (nf == 0) ? 1 : (nf > 64) ? 64 : nf;
    sent = 0;
    set_config(lr, nf);
    while (sent < items) begin
      o = $urandom_range(99) < 70;
      lab = 1'($urandom_range(1));
      for (int j = 0; j < n; j++) begin
        mode = $urandom_range(99);
        if (mode < 10) x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else if (mode < 55) x = $signed(16'($urandom_range(1023))) - 16'sd512;
        else x = 16'($urandom);
        send(o, x, lab);
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    logic signed [15:0] edge_vals [12];
    edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff, 16'sh0100,
                  16'shff00, 16'sh5555, 16'shaaaa, 16'sh0800, 16'shf800, 16'sh0064};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_config(16'd6554, 7'd1);
    for (int i = 0; i < 12; i++) send(1'(i % 2), edge_vals[i], 1'((i / 2) % 2));
    settle();
    set_config(16'd65535, 7'd2);
    send(1'b1, 16'sh7fff, 1'b0);
    send(1'b1, 16'sh8000, 1'b0);
    send(1'b0, 16'sh1234, 1'b1);
    send(1'b1, 16'shedcb, 1'b1);
    settle();
    run_phase(16'd65535, 7'd1, 150);
    run_phase(16'd0, 7'd0, 60);
    run_phase(16'd20000, 7'd127, 190);
    calm = 1'b1;
    run_phase(16'd3000, 7'd3, 200);
    calm = 1'b0;
    run_phase(16'd45000, 7'd8, 250);
    run_phase(16'd1, 7'd64, 130);
    run_phase(16'd6554, 7'd2, 250);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
